@@ rtl/core/capped_bond_spring_force_macros.svh @@
// Assertion macros used by the checker file of the bond force block.
`ifndef CAPPED_BOND_SPRING_FORCE_MACROS_SVH
`define CAPPED_BOND_SPRING_FORCE_MACROS_SVH

// Implication that must hold in the same cycle, masked while reset is low.
`define CBSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle that demands a consequence in the next cycle.
`define CBSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cbsf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbsf_pkg
// Widths, cell state types and constants of the capped bond spring force block.
// ----------------------------------------------------------------------------
package cbsf_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int DW      = COORD_WIDTH + 1;     // magnitude of one separation component
    localparam int SQW     = 2 * DW;              // sum of squares
    localparam int RTW     = DW;                  // square root
    localparam int SRW     = RTW + 2;             // square root partial remainder
    localparam int SQT_W   = SRW + 2;             // remainder with two radicand bits
    localparam int SQ_CELLS = RTW;
    localparam int DVW     = RTW;                 // divisor and division remainder
    localparam int QW      = COORD_WIDTH;         // dividend shift and quotient
    localparam int LIM_W   = 24;
    localparam int K_W     = 32;
    localparam int RAD_W   = 31;
    localparam int FW      = 48;
    localparam int DIST_W  = 34;
    localparam int PW      = DW + RAD_W;          // separation times radius
    localparam int NW      = RTW + FRAC_BITS;     // scaled deformation numerator
    localparam int NHW     = NW - LIM_W;
    localparam int KMW     = K_W + LIM_W;
    localparam int KMH     = KMW / 2;
    localparam int PPW     = DW + KMH;
    localparam int TW      = DW + KMW;
    localparam int VW      = TW - 2 * FRAC_BITS;
    localparam int CSW     = COORD_WIDTH + 3;

    localparam logic [VW-1:0] V_NEG_LIM = VW'(1) << (FW - 1);
    localparam logic [VW-1:0] V_POS_LIM = V_NEG_LIM - VW'(1);
    localparam logic signed [CSW-1:0] C_MAX = CSW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [CSW-1:0] C_MIN = CSW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

    localparam logic REG_SPRING_K    = 1'b0;
    localparam logic REG_DEFORM_LIMIT = 1'b1;

    typedef struct packed {
        logic [SRW-1:0] rem;
        logic [RTW-1:0] root;
        logic [SQW-1:0] rad;
    } t_sqrt_st;

    typedef struct packed {
        logic [DVW-1:0] rem;
        logic [DVW-1:0] dvs;
        logic [QW-1:0]  dvd;
        logic [QW-1:0]  quo;
    } t_div_st;

endpackage
`default_nettype wire

@@ rtl/core/cbsf_sqrt_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbsf_sqrt_cell
// One root bit of a pipelined restoring integer square root.
// ----------------------------------------------------------------------------
module cbsf_sqrt_cell (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  cbsf_pkg::t_sqrt_st       i_st,
    output cbsf_pkg::t_sqrt_st       o_st
);

    logic [cbsf_pkg::SQT_W-1:0] w_part;
    logic [cbsf_pkg::SQT_W-1:0] w_trial;
    logic                       w_take;
    cbsf_pkg::t_sqrt_st         n_st;
    cbsf_pkg::t_sqrt_st         r_st;

    always_comb begin
        w_part  = {i_st.rem, i_st.rad[cbsf_pkg::SQW-1 -: 2]};
        w_trial = {{(cbsf_pkg::SQT_W - cbsf_pkg::RTW - 2){1'b0}}, i_st.root, 2'b01};
        w_take  = (w_part >= w_trial);
        n_st.rem  = w_take ? cbsf_pkg::SRW'(w_part - w_trial) : w_part[cbsf_pkg::SRW-1:0];
        n_st.root = {i_st.root[cbsf_pkg::RTW-2:0], w_take};
        n_st.rad  = {i_st.rad[cbsf_pkg::SQW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule
`default_nettype wire

@@ rtl/core/cbsf_div_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbsf_div_cell
// One quotient bit of a pipelined restoring divider.
// ----------------------------------------------------------------------------
module cbsf_div_cell (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  cbsf_pkg::t_div_st   i_st,
    output cbsf_pkg::t_div_st   o_st
);

    logic [cbsf_pkg::DVW:0] w_part;
    logic [cbsf_pkg::DVW:0] w_dvs;
    logic                   w_take;
    cbsf_pkg::t_div_st      n_st;
    cbsf_pkg::t_div_st      r_st;

    // The incoming remainder is below the divisor, so the result fits again.
    always_comb begin
        w_part = {i_st.rem, i_st.dvd[cbsf_pkg::QW-1]};
        w_dvs  = {1'b0, i_st.dvs};
        w_take = (w_part >= w_dvs);
        n_st.rem = w_take ? cbsf_pkg::DVW'(w_part - w_dvs) : w_part[cbsf_pkg::DVW-1:0];
        n_st.dvs = i_st.dvs;
        n_st.dvd = {i_st.dvd[cbsf_pkg::QW-2:0], 1'b0};
        n_st.quo = {i_st.quo[cbsf_pkg::QW-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule
`default_nettype wire

@@ rtl/core/capped_bond_spring_force.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// capped_bond_spring_force
// Linear bond spring force with a capped relative deformation, per particle pair.
// ----------------------------------------------------------------------------
// One bonded pair enters per transaction on the input channel (i_in_valid,
// o_in_ready); one result leaves per transaction on the output channel
// (o_out_valid, i_out_ready), in order. The pipeline takes a new pair every
// cycle unless the receiver stalls it. The depth is set by the square root
// chain, one cell per root bit (33), and the deformation divider, one cell
// per quotient bit (24); the contact point dividers run beside the root
// chain.
// When the receiver stalls, the whole pipeline holds and o_in_ready falls
// until the waiting result is taken; a pipeline with free slots never
// refuses input while the output register is empty.
// Stiffness and deformation limit sit in APB registers at 0x0 and 0x4.
// Reset empties the pipeline and loads the register reset values; it is
// synchronous and active low.
// ----------------------------------------------------------------------------
module capped_bond_spring_force (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic signed [31:0] i_first_x,
    input  wire logic signed [31:0] i_first_y,
    input  wire logic signed [31:0] i_first_z,
    input  wire logic signed [31:0] i_second_x,
    input  wire logic signed [31:0] i_second_y,
    input  wire logic signed [31:0] i_second_z,
    input  wire logic [30:0] i_second_radius,
    input  wire logic [31:0] i_rest_length,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y,
    output logic signed [47:0] o_force_z,
    output logic signed [31:0] o_contact_x,
    output logic signed [31:0] o_contact_y,
    output logic signed [31:0] o_contact_z,
    output logic      [33:0] o_distance,
    output logic             o_was_capped,
    output logic             o_zero_distance
);

    localparam int CW  = cbsf_pkg::COORD_WIDTH;
    localparam int DW  = cbsf_pkg::DW;
    localparam int NSQ = cbsf_pkg::SQ_CELLS;
    localparam int NDV = cbsf_pkg::LIM_W;
    localparam int QW  = cbsf_pkg::QW;

    logic w_en;
    logic w_wr;

    // Configuration registers.
    logic [cbsf_pkg::K_W-1:0]   r_spring_k;
    logic [cbsf_pkg::LIM_W-1:0] r_deform_limit;

    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring_k     <= 32'd65536;
            r_deform_limit <= '0;
        end else if (w_wr) begin
            unique case (paddr[2])
                cbsf_pkg::REG_SPRING_K:     r_spring_k     <= pwdata;
                cbsf_pkg::REG_DEFORM_LIMIT: r_deform_limit <= pwdata[cbsf_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cbsf_pkg::REG_SPRING_K:     prdata = r_spring_k;
            cbsf_pkg::REG_DEFORM_LIMIT: prdata = {{(32 - cbsf_pkg::LIM_W){1'b0}}, r_deform_limit};
            default:                    prdata = '0;
        endcase
    end

    // The whole pipeline advances unless a finished result is being held.
    logic r_o_valid;
    assign w_en       = !r_o_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Input stage.
    logic                 r_s0_valid;
    logic signed [CW-1:0] r_s0_p1 [3];
    logic signed [CW-1:0] r_s0_p2 [3];
    logic [cbsf_pkg::RAD_W-1:0] r_s0_rad;
    logic [CW-1:0]        r_s0_r0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_p1[0] <= i_first_x;
            r_s0_p1[1] <= i_first_y;
            r_s0_p1[2] <= i_first_z;
            r_s0_p2[0] <= i_second_x;
            r_s0_p2[1] <= i_second_y;
            r_s0_p2[2] <= i_second_z;
            r_s0_rad   <= i_second_radius;
            r_s0_r0    <= i_rest_length;
        end
    end

    // Separation: sign and magnitude of each component.
    logic                 r_a_valid;
    logic [DW-1:0]        r_a_ad [3];
    logic                 r_a_sgn [3];
    logic signed [CW-1:0] r_a_p2 [3];
    logic [cbsf_pkg::RAD_W-1:0] r_a_rad;
    logic [CW-1:0]        r_a_r0;
    logic signed [DW-1:0] w_d [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_d[j] = {r_s0_p1[j][CW-1], r_s0_p1[j]} - {r_s0_p2[j][CW-1], r_s0_p2[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_a_sgn[j] <= w_d[j][DW-1];
                r_a_ad[j]  <= w_d[j][DW-1] ? DW'(-w_d[j]) : DW'(w_d[j]);
                r_a_p2[j]  <= r_s0_p2[j];
            end
            r_a_rad <= r_s0_rad;
            r_a_r0  <= r_s0_r0;
        end
    end

    // Squares and radius products.
    logic                 r_b_valid;
    logic [cbsf_pkg::SQW-1:0] r_b_sq [3];
    logic [cbsf_pkg::PW-1:0]  r_b_pr [3];
    logic [DW-1:0]        r_b_ad [3];
    logic                 r_b_sgn [3];
    logic signed [CW-1:0] r_b_p2 [3];
    logic [CW-1:0]        r_b_r0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_b_sq[j]  <= r_a_ad[j] * r_a_ad[j];
                r_b_pr[j]  <= r_a_ad[j] * r_a_rad;
                r_b_ad[j]  <= r_a_ad[j];
                r_b_sgn[j] <= r_a_sgn[j];
                r_b_p2[j]  <= r_a_p2[j];
            end
            r_b_r0 <= r_a_r0;
        end
    end

    // Sum of squares and divider set-up; index 0 of the side pipe is this stage.
    cbsf_pkg::t_sqrt_st   r_c_sq;
    cbsf_pkg::t_div_st    r_c_cd [3];
    logic [QW-1:0]        w_phi [3];
    logic                 w_ovc [3];

    logic                 r_sp_valid [NSQ+1];
    logic [DW-1:0]        r_sp_ad [NSQ+1][3];
    logic                 r_sp_sgn [NSQ+1][3];
    logic signed [CW-1:0] r_sp_p2 [NSQ+1][3];
    logic                 r_sp_ovc [NSQ+1][3];
    logic [CW-1:0]        r_sp_r0 [NSQ+1];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_phi[j] = r_b_pr[j][cbsf_pkg::PW-1:QW];
            w_ovc[j] = (w_phi[j] >= r_b_r0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_sq.rem  <= '0;
            r_c_sq.root <= '0;
            r_c_sq.rad  <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            for (int j = 0; j < 3; j++) begin
                r_c_cd[j].rem <= w_ovc[j] ? '0 : {1'b0, w_phi[j]};
                r_c_cd[j].dvs <= {1'b0, r_b_r0};
                r_c_cd[j].dvd <= r_b_pr[j][QW-1:0];
                r_c_cd[j].quo <= '0;
                r_sp_ad[0][j]  <= r_b_ad[j];
                r_sp_sgn[0][j] <= r_b_sgn[j];
                r_sp_p2[0][j]  <= r_b_p2[j];
                r_sp_ovc[0][j] <= w_ovc[j];
            end
            r_sp_r0[0] <= r_b_r0;
            for (int k = 1; k <= NSQ; k++) begin
                r_sp_ad[k]  <= r_sp_ad[k-1];
                r_sp_sgn[k] <= r_sp_sgn[k-1];
                r_sp_p2[k]  <= r_sp_p2[k-1];
                r_sp_ovc[k] <= r_sp_ovc[k-1];
                r_sp_r0[k]  <= r_sp_r0[k-1];
            end
        end
    end

    // Square root chain and the three contact offset dividers.
    cbsf_pkg::t_sqrt_st w_sq [NSQ+1];
    cbsf_pkg::t_div_st  w_cd [3][QW+1];
    logic [QW-1:0]      r_cq [3];

    assign w_sq[0] = r_c_sq;

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        cbsf_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_st  (w_sq[k]),
            .o_st  (w_sq[k+1])
        );
    end

    for (genvar j = 0; j < 3; j++) begin : g_cdiv
        assign w_cd[j][0] = r_c_cd[j];
        for (genvar k = 0; k < QW; k++) begin : g_cell
            cbsf_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_st  (w_cd[j][k]),
                .o_st  (w_cd[j][k+1])
            );
        end
    end

    // The contact quotients finish one cell ahead of the root.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_cq[j] <= w_cd[j][QW].quo;
            end
        end
    end

    // Deformation set-up and contact point; index 0 of the second side pipe.
    logic [cbsf_pkg::RTW-1:0] w_dist;
    logic [cbsf_pkg::RTW-1:0] w_r0x;
    logic                     w_zero;
    logic                     w_rneg;
    logic [cbsf_pkg::RTW-1:0] w_n;
    logic [cbsf_pkg::NW-1:0]  w_nn;
    logic [cbsf_pkg::RTW-1:0] w_nhi;
    logic                     w_ovr;
    logic [QW:0]              w_off [3];
    logic signed [cbsf_pkg::CSW-1:0] w_cs [3];
    logic signed [CW-1:0]     w_ct [3];

    always_comb begin
        w_dist = w_sq[NSQ].root;
        w_r0x  = {1'b0, r_sp_r0[NSQ]};
        w_zero = (w_dist == '0);
        w_rneg = (w_dist < w_r0x);
        w_n    = w_rneg ? (w_r0x - w_dist) : (w_dist - w_r0x);
        w_nn   = {w_n, {cbsf_pkg::FRAC_BITS{1'b0}}};
        w_nhi  = {{(cbsf_pkg::RTW - cbsf_pkg::NHW){1'b0}}, w_nn[cbsf_pkg::NW-1:NDV]};
        w_ovr  = (w_nhi >= w_dist);
        for (int j = 0; j < 3; j++) begin
            if (r_sp_r0[NSQ] == '0) begin
                w_off[j] = '0;
            end else if (r_sp_ovc[NSQ][j]) begin
                w_off[j] = {1'b1, {QW{1'b0}}};
            end else begin
                w_off[j] = {1'b0, r_cq[j]};
            end
            w_cs[j] = r_sp_sgn[NSQ][j]
                ? ({{3{r_sp_p2[NSQ][j][CW-1]}}, r_sp_p2[NSQ][j]} - {2'b00, w_off[j]})
                : ({{3{r_sp_p2[NSQ][j][CW-1]}}, r_sp_p2[NSQ][j]} + {2'b00, w_off[j]});
            if (w_cs[j] > cbsf_pkg::C_MAX) begin
                w_ct[j] = cbsf_pkg::C_MAX[CW-1:0];
            end else if (w_cs[j] < cbsf_pkg::C_MIN) begin
                w_ct[j] = cbsf_pkg::C_MIN[CW-1:0];
            end else begin
                w_ct[j] = w_cs[j][CW-1:0];
            end
        end
    end

    cbsf_pkg::t_div_st        r_e_dv;
    logic                     r_dp_valid [NDV+1];
    logic [DW-1:0]            r_dp_ad [NDV+1][3];
    logic                     r_dp_sgn [NDV+1][3];
    logic signed [CW-1:0]     r_dp_ct [NDV+1][3];
    logic [cbsf_pkg::RTW-1:0] r_dp_dist [NDV+1];
    logic                     r_dp_zero [NDV+1];
    logic                     r_dp_rneg [NDV+1];
    logic                     r_dp_ovr [NDV+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_dv.rem <= (w_ovr || w_zero) ? '0 : w_nhi;
            r_e_dv.dvs <= w_dist;
            r_e_dv.dvd <= {w_nn[NDV-1:0], {(QW - NDV){1'b0}}};
            r_e_dv.quo <= '0;
            for (int j = 0; j < 3; j++) begin
                r_dp_ad[0][j]  <= r_sp_ad[NSQ][j];
                r_dp_sgn[0][j] <= r_sp_sgn[NSQ][j];
                r_dp_ct[0][j]  <= w_ct[j];
            end
            r_dp_dist[0] <= w_dist;
            r_dp_zero[0] <= w_zero;
            r_dp_rneg[0] <= w_rneg;
            r_dp_ovr[0]  <= w_ovr;
            for (int k = 1; k <= NDV; k++) begin
                r_dp_ad[k]   <= r_dp_ad[k-1];
                r_dp_sgn[k]  <= r_dp_sgn[k-1];
                r_dp_ct[k]   <= r_dp_ct[k-1];
                r_dp_dist[k] <= r_dp_dist[k-1];
                r_dp_zero[k] <= r_dp_zero[k-1];
                r_dp_rneg[k] <= r_dp_rneg[k-1];
                r_dp_ovr[k]  <= r_dp_ovr[k-1];
            end
        end
    end

    // Relative deformation divider.
    cbsf_pkg::t_div_st w_dv [NDV+1];

    assign w_dv[0] = r_e_dv;

    for (genvar k = 0; k < NDV; k++) begin : g_rdiv
        cbsf_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_st  (w_dv[k]),
            .o_st  (w_dv[k+1])
        );
    end

    // Cap the deformation magnitude.
    logic [NDV-1:0]        w_q;
    logic                  w_cap;
    logic                  r_f_valid;
    logic [NDV-1:0]        r_f_mag;
    logic                  r_f_cap;
    logic [DW-1:0]         r_f_ad [3];
    logic                  r_f_neg [3];
    logic signed [CW-1:0]  r_f_ct [3];
    logic [cbsf_pkg::RTW-1:0] r_f_dist;
    logic                  r_f_zero;

    always_comb begin
        w_q   = w_dv[NDV].quo[NDV-1:0];
        w_cap = !r_dp_zero[NDV] && (r_dp_ovr[NDV] || (w_q > r_deform_limit));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_dp_zero[NDV]) begin
                r_f_mag <= '0;
            end else if (w_cap) begin
                r_f_mag <= r_deform_limit;
            end else begin
                r_f_mag <= w_q;
            end
            r_f_cap <= w_cap;
            for (int j = 0; j < 3; j++) begin
                r_f_ad[j]  <= r_dp_ad[NDV][j];
                r_f_neg[j] <= r_dp_sgn[NDV][j] != r_dp_rneg[NDV];
                r_f_ct[j]  <= r_dp_ct[NDV][j];
            end
            r_f_dist <= r_dp_dist[NDV];
            r_f_zero <= r_dp_zero[NDV];
        end
    end

    // Stiffness times deformation.
    logic                     r_g_valid;
    logic [cbsf_pkg::KMW-1:0] r_g_km;
    logic                     r_g_cap;
    logic [DW-1:0]            r_g_ad [3];
    logic                     r_g_neg [3];
    logic signed [CW-1:0]     r_g_ct [3];
    logic [cbsf_pkg::RTW-1:0] r_g_dist;
    logic                     r_g_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_km   <= r_spring_k * r_f_mag;
            r_g_cap  <= r_f_cap;
            r_g_ad   <= r_f_ad;
            r_g_neg  <= r_f_neg;
            r_g_ct   <= r_f_ct;
            r_g_dist <= r_f_dist;
            r_g_zero <= r_f_zero;
        end
    end

    // Partial products of separation times the stiffness term.
    logic                     r_h_valid;
    logic [cbsf_pkg::PPW-1:0] r_h_pl [3];
    logic [cbsf_pkg::PPW-1:0] r_h_ph [3];
    logic                     r_h_cap;
    logic                     r_h_neg [3];
    logic signed [CW-1:0]     r_h_ct [3];
    logic [cbsf_pkg::RTW-1:0] r_h_dist;
    logic                     r_h_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_h_pl[j] <= r_g_ad[j] * r_g_km[cbsf_pkg::KMH-1:0];
                r_h_ph[j] <= r_g_ad[j] * r_g_km[cbsf_pkg::KMW-1:cbsf_pkg::KMH];
            end
            r_h_cap  <= r_g_cap;
            r_h_neg  <= r_g_neg;
            r_h_ct   <= r_g_ct;
            r_h_dist <= r_g_dist;
            r_h_zero <= r_g_zero;
        end
    end

    // Final sum, scaling, saturation and sign.
    logic [cbsf_pkg::TW-1:0] w_t [3];
    logic [cbsf_pkg::VW-1:0] w_v [3];
    logic [cbsf_pkg::FW-1:0] w_mag [3];
    logic [cbsf_pkg::FW-1:0] w_f [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_t[j] = {{(cbsf_pkg::TW - cbsf_pkg::PPW){1'b0}}, r_h_pl[j]}
                   + {r_h_ph[j], {cbsf_pkg::KMH{1'b0}}};
            w_v[j] = w_t[j][cbsf_pkg::TW-1:2*cbsf_pkg::FRAC_BITS];
            if (w_v[j] > cbsf_pkg::V_NEG_LIM) begin
                w_v[j] = cbsf_pkg::V_NEG_LIM;
            end
            if (!r_h_neg[j] && (w_v[j] > cbsf_pkg::V_POS_LIM)) begin
                w_v[j] = cbsf_pkg::V_POS_LIM;
            end
            w_mag[j] = w_v[j][cbsf_pkg::FW-1:0];
            w_f[j]   = r_h_neg[j] ? (~w_mag[j] + 1'b1) : w_mag[j];
        end
    end

    logic [cbsf_pkg::FW-1:0]  r_o_force [3];
    logic signed [CW-1:0]     r_o_ct [3];
    logic [cbsf_pkg::RTW-1:0] r_o_dist;
    logic                     r_o_cap;
    logic                     r_o_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_force <= w_f;
            r_o_ct    <= r_h_ct;
            r_o_dist  <= r_h_dist;
            r_o_cap   <= r_h_cap;
            r_o_zero  <= r_h_zero;
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            for (int k = 0; k <= NSQ; k++) begin
                r_sp_valid[k] <= 1'b0;
            end
            for (int k = 0; k <= NDV; k++) begin
                r_dp_valid[k] <= 1'b0;
            end
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid    <= i_in_valid;
            r_a_valid     <= r_s0_valid;
            r_b_valid     <= r_a_valid;
            r_sp_valid[0] <= r_b_valid;
            for (int k = 1; k <= NSQ; k++) begin
                r_sp_valid[k] <= r_sp_valid[k-1];
            end
            r_dp_valid[0] <= r_sp_valid[NSQ];
            for (int k = 1; k <= NDV; k++) begin
                r_dp_valid[k] <= r_dp_valid[k-1];
            end
            r_f_valid <= r_dp_valid[NDV];
            r_g_valid <= r_f_valid;
            r_h_valid <= r_g_valid;
            r_o_valid <= r_h_valid;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_force_x       = r_o_force[0];
    assign o_force_y       = r_o_force[1];
    assign o_force_z       = r_o_force[2];
    assign o_contact_x     = r_o_ct[0];
    assign o_contact_y     = r_o_ct[1];
    assign o_contact_z     = r_o_ct[2];
    assign o_distance      = {{(cbsf_pkg::DIST_W - cbsf_pkg::RTW){1'b0}}, r_o_dist};
    assign o_was_capped    = r_o_cap;
    assign o_zero_distance = r_o_zero;

endmodule
`default_nettype wire

@@ rtl/core/cbsf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbsf_checker
// Port-level checks of the capped bond spring force block.
// ----------------------------------------------------------------------------
`include "capped_bond_spring_force_macros.svh"

module cbsf_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [47:0] o_force_x,
    input wire logic signed [47:0] o_force_y,
    input wire logic signed [47:0] o_force_z,
    input wire logic        [33:0] o_distance,
    input wire logic               o_was_capped,
    input wire logic               o_zero_distance
);

    logic         w_held;
    logic [179:0] w_pay;
    logic         w_zero_out;
    logic         w_zero_ok;
    logic         w_live;

    assign w_held     = o_out_valid && !i_out_ready;
    assign w_pay      = {o_force_x, o_force_y, o_force_z, o_distance,
                         o_was_capped, o_zero_distance};
    assign w_zero_out = o_out_valid && o_zero_distance;
    assign w_zero_ok  = (o_force_x == 48'sd0) && (o_force_y == 48'sd0)
                     && (o_force_z == 48'sd0) && (o_distance == 34'd0) && !o_was_capped;
    assign w_live     = o_out_valid && !o_zero_distance;

    // A held result keeps its value until the transaction completes.
    `CBSF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_held, o_out_valid && $stable(w_pay), "held data moved")

    // An empty output register never blocks the input side.
    `CBSF_ASSERT(a_in_ready, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input refused")

    // A coincident pair yields no force and is never reported as capped.
    `CBSF_ASSERT(a_zero_force, i_clk, i_rst_n, w_zero_out |-> w_zero_ok, "result for zero distance")

    // The zero flag agrees with the reported distance.
    `CBSF_ASSERT(a_zero_flag, i_clk, i_rst_n, w_live |-> o_distance != 34'd0, "unflagged zero")

endmodule

bind capped_bond_spring_force cbsf_checker u_cbsf_checker (.*);
`default_nettype wire

@@ verif/capped_bond_spring_force_tb.sv @@
// ----------------------------------------------------------------------------
// capped_bond_spring_force_tb
// Self-checking testbench for the capped bond spring force pipeline.
// ----------------------------------------------------------------------------
// Bonded pairs go in through the input handshake. An in-line predictor works
// out force, contact point, distance and flags for each accepted pair.
// Each transaction on the output channel is compared field by field with the
// oldest expected result. Stiffness and deformation limit are changed over
// APB between phases. The sender and the receiver both idle at random, and
// one long receiver stall fills the pipeline.
// ----------------------------------------------------------------------------
module capped_bond_spring_force_tb;

    localparam logic [2:0] ADDR_SPRING_K     = {cbsf_pkg::REG_SPRING_K, 2'b00};
    localparam logic [2:0] ADDR_DEFORM_LIMIT = {cbsf_pkg::REG_DEFORM_LIMIT, 2'b00};
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic signed [31:0] p1 [3];
        logic signed [31:0] p2 [3];
        logic [30:0] radius;
        logic [31:0] rest;
    } t_pair;

    typedef struct {
        logic [47:0] force_v [3];
        logic [31:0] contact [3];
        logic [33:0] sep_len;
        logic capped;
        logic zero;
    } t_bond_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [31:0] i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic signed [31:0] i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic [30:0] i_second_radius = '0;
    logic [31:0] i_rest_length = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [47:0] o_force_x, o_force_y, o_force_z;
    logic signed [31:0] o_contact_x, o_contact_y, o_contact_z;
    logic [33:0] o_distance;
    logic o_was_capped, o_zero_distance;

    logic [31:0] stiffness = 32'd65536;
    logic [23:0] deform_cap = 24'd0;
    t_bond_result expected_bonds[$];
    int error_count = 0;
    bit calm = 1'b0;
    bit hold_off_req = 1'b0;

    capped_bond_spring_force i_dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] isqrt(logic [127:0] s);
        logic [127:0] r, c;
        r = '0;
        for (int b = 55; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        return r[63:0];
    endfunction

    function automatic t_bond_result predict_bond(t_pair p);
        t_bond_result res;
        longint d [3];
        logic [127:0] ad [3];
        logic [127:0] sum, n, mag, prod, v, off;
        logic [63:0] sep;
        longint c;
        bit rneg, neg;
        sum = '0;
        mag = '0;
        rneg = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(p.p1[i]) - longint'(p.p2[i]);
            ad[i] = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
            sum += ad[i] * ad[i];
        end
        sep = isqrt(sum);
        res.zero = (sep == 0);
        res.capped = 1'b0;
        if (!res.zero) begin
            rneg = sep < p.rest;
            n = rneg ? 128'(p.rest) - 128'(sep) : 128'(sep) - 128'(p.rest);
            mag = (n << cbsf_pkg::FRAC_BITS) / 128'(sep);
            if (mag > deform_cap) begin
                mag = 128'(deform_cap);
                res.capped = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            v = '0;
            neg = 1'b0;
            if (!res.zero) begin
                neg = (d[i] < 0) != rneg;
                prod = ad[i] * (128'(stiffness) * mag);
                v = prod >> (2 * cbsf_pkg::FRAC_BITS);
                if (v > (128'd1 << 47)) v = 128'd1 << 47;
                if (!neg && v > (128'd1 << 47) - 1) v = (128'd1 << 47) - 1;
            end
            res.force_v[i] = neg ? -v[47:0] : v[47:0];
            off = '0;
            if (p.rest != 0) begin
                off = (ad[i] * 128'(p.radius)) / 128'(p.rest);
                if (off > (128'd1 << 50)) off = 128'd1 << 50;
            end
            c = longint'(p.p2[i]) + ((d[i] < 0) ? -longint'(off) : longint'(off));
            if (c > 64'sd2147483647) c = 64'sd2147483647;
            if (c < -64'sd2147483648) c = -64'sd2147483648;
            res.contact[i] = c[31:0];
        end
        res.sep_len = (sep > 64'h3_FFFF_FFFF) ? 34'h3_FFFF_FFFF : sep[33:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Predict on accepted input, check on accepted output.
    always @(posedge i_clk) begin
        t_pair p;
        t_bond_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bonds.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_distance), 64'd0);
            end else begin
                e = expected_bonds.pop_front();
                if (o_force_x !== e.force_v[0]) report_mismatch("force_x", o_force_x, e.force_v[0]);
                if (o_force_y !== e.force_v[1]) report_mismatch("force_y", o_force_y, e.force_v[1]);
                if (o_force_z !== e.force_v[2]) report_mismatch("force_z", o_force_z, e.force_v[2]);
                if (o_contact_x !== e.contact[0])
                    report_mismatch("contact_x", o_contact_x, e.contact[0]);
                if (o_contact_y !== e.contact[1])
                    report_mismatch("contact_y", o_contact_y, e.contact[1]);
                if (o_contact_z !== e.contact[2])
                    report_mismatch("contact_z", o_contact_z, e.contact[2]);
                if (o_distance !== e.sep_len)
                    report_mismatch("distance", o_distance, e.sep_len);
                if (o_was_capped !== e.capped)
                    report_mismatch("was_capped", o_was_capped, e.capped);
                if (o_zero_distance !== e.zero)
                    report_mismatch("zero_distance", o_zero_distance, e.zero);
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            p.p1[0] = i_first_x;  p.p1[1] = i_first_y;  p.p1[2] = i_first_z;
            p.p2[0] = i_second_x; p.p2[1] = i_second_y; p.p2[2] = i_second_z;
            p.radius = i_second_radius;
            p.rest = i_rest_length;
            expected_bonds.insert(expected_bonds.size(), predict_bond(p));
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                for (n = 0; n < 300; n++) @(negedge i_clk);
                hold_off_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SPRING_K) stiffness = data;
        else deform_cap = data[23:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_bonds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] k, logic [23:0] lim);
        wait_idle();
        apb_write(ADDR_SPRING_K, k);
        apb_write(ADDR_DEFORM_LIMIT, {8'd0, lim});
    endtask

    task automatic send_pair(t_pair p);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first_x <= p.p1[0];  i_first_y <= p.p1[1];  i_first_z <= p.p1[2];
        i_second_x <= p.p2[0]; i_second_y <= p.p2[1]; i_second_z <= p.p2[2];
        i_second_radius <= p.radius;
        i_rest_length <= p.rest;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic t_pair make_pair(logic signed [31:0] a, logic signed [31:0] b,
                                        logic [30:0] rad, logic [31:0] rest);
        t_pair p;
        for (int i = 0; i < 3; i++) begin
            p.p1[i] = a;
            p.p2[i] = b;
        end
        p.radius = rad;
        p.rest = rest;
        return p;
    endfunction

    // Mostly physically sensible pairs, with some fully random ones.
    function automatic t_pair random_pair();
        t_pair p;
        int sel;
        logic [31:0] dist_hint;
        sel = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            if (sel < 7) begin
                p.p2[i] = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                p.p1[i] = p.p2[i] + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            end else begin
                p.p1[i] = $urandom;
                p.p2[i] = $urandom;
            end
        end
        if (sel < 7) begin
            dist_hint = $urandom_range(32'h0000_1000, 32'h0003_0000);
            p.rest = dist_hint;
            p.radius = 31'(dist_hint >> $urandom_range(1, 3));
        end else begin
            p.rest = $urandom;
            p.radius = 31'($urandom);
            if (p.rest == 0) p.rest = 1;
        end
        return p;
    endfunction

    task automatic test_directed();
        t_pair p;
        send_pair(make_pair(32'sd0, 32'sd0, 31'd0, 32'd65536));             // zero distance
        send_pair(make_pair(32'sd123456, 32'sd123456, 31'h7FFF_FFFF, 32'd1));
        send_pair(make_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 32'd1));
        send_pair(make_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_pair(make_pair(32'sd65536, 32'sd0, 31'd32768, 32'd0));         // zero rest length
        send_pair(make_pair(32'sd65536, 32'sd0, 31'd32768, 32'hFFFF_FFFF));
        send_pair(make_pair(32'sd0, 32'sd65536, 31'd65536, 32'd131072));
        send_pair(make_pair(-32'sd1, 32'sd0, 31'd1, 32'd1));
        p = make_pair(32'sd0, 32'sd0, 31'd65536, 32'd65536);
        p.p1[0] = 32'sd100000;
        send_pair(p);
        p.p1[0] = 32'sd0;
        p.p2[2] = 32'sh7FFF_FFFF;
        send_pair(p);
        end_burst();
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_pair(random_pair());
        end_burst();
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        test_random(150);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();                              // reset settings: zero limit
        set_config(32'd65536, 24'hFF_FFFF);
        test_directed();
        set_config(32'hFFFF_FFFF, 24'hFF_FFFF);
        test_directed();
        test_random(200);
        set_config(32'd0, 24'h00_8000);
        test_random(200);
        set_config(32'd65536, 24'h00_4000);
        test_random(400);
        test_backpressure();
        set_config($urandom, 24'($urandom));
        test_random(400);
        calm = 1'b1;
        set_config(32'd131072, 24'h01_0000);
        test_random(300);
        wait_idle();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
